/* rtl/alle_pkg.sv */
`timescale 1ns / 1ps

package alle_pkg;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_ERASE      = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot;
        logic [7:0] count;
        logic [7:0] first_slot;
        logic [7:0] last_slot;
    } t_out;

endpackage

/* rtl/alle_store.sv */
`timescale 1ns / 1ps

module alle_store #(
    parameter int SW         = 8,
    parameter int NSLOTS     = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [SW-1:0]         i_rd_a,
    input  logic [SW-1:0]         i_rd_b,
    output logic [SW:0]           o_nx_a,
    output logic [SW:0]           o_nx_b,
    output logic [SW-1:0]         o_pv_a,
    input  logic                  i_nx_we,
    input  logic [SW-1:0]         i_nx_wa,
    input  logic [SW:0]           i_nx_wd,
    input  logic                  i_pv_we,
    input  logic [SW-1:0]         i_pv_wa,
    input  logic [SW-1:0]         i_pv_wd,
    input  logic                  i_dt_we,
    input  logic [SW-1:0]         i_dt_wa,
    input  logic [DATA_WIDTH-1:0] i_dt_wd
);

    // next memory word: {in_use, next_slot}
    logic [SW:0]           next_mem [NSLOTS];
    logic [SW-1:0]         prev_mem [NSLOTS];
    logic [DATA_WIDTH-1:0] data_mem [NSLOTS];

    always_ff @(posedge i_clk) begin
        if (i_nx_we) begin
            next_mem[i_nx_wa] <= i_nx_wd;
        end
        if (i_rd_en) begin
            o_nx_a <= next_mem[i_rd_a];
            o_nx_b <= next_mem[i_rd_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pv_we) begin
            prev_mem[i_pv_wa] <= i_pv_wd;
        end
        if (i_rd_en) begin
            o_pv_a <= prev_mem[i_rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dt_we) begin
            data_mem[i_dt_wa] <= i_dt_wd;
        end
    end

endmodule

/* rtl/array_linked_list_engine.sv */
`timescale 1ns / 1ps

// Doubly linked list engine with a free chain, slot 0 as sentinel.
// Command channel: start/i_in; a transfer happens at a clock edge with
// start high and busy low. opcode: push back, push front, insert after
// position, erase position, pop back.
// Result channel: o_valid marks o_result for exactly one cycle; it carries
// status, slot touched, element count, head and tail slots after the op.
// The receiver cannot stall; every command yields exactly one result.
// Sequence: command transfer edge, then execute states S_E1 (link read data
// check plus first write set) and S_E2 (the neighbor write set); o_valid is
// high once the state is back in S_IDLE, and busy drops in that same cycle,
// so a new command is taken only after the last one's result. A failed
// command ends in S_E1. S_E2 exists because the next-link memory's single
// write port takes two writes per op, after a registered read.
// Reset: synchronous, active low. After reset an init sweep writes all
// CAPACITY+1 slots, one per cycle, with busy held high.
module array_linked_list_engine
    import alle_pkg::*;
#(
    parameter int CAPACITY   = 255,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_valid,
    output t_out o_result
);

    localparam int NSLOTS = CAPACITY + 1;
    localparam int SW     = $clog2(NSLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY);
    localparam logic [16:0]   CAP17     = 17'(CAPACITY);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_E1   = 2'd2;
    localparam logic [1:0] S_E2   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [SW-1:0]         r_init,  n_init;
    logic [2:0]            r_op,    n_op;
    logic [DATA_WIDTH-1:0] r_val,   n_val;
    logic                  r_pos_ok, n_pos_ok;
    logic [SW-1:0]         r_tgt,   n_tgt;
    logic [SW-1:0]         r_free,  n_free;
    logic [SW-1:0]         r_count, n_count;
    logic [SW-1:0]         r_head,  n_head;
    logic [SW-1:0]         r_tail,  n_tail;
    logic [SW-1:0]         r_slot,  n_slot;
    logic [SW-1:0]         r_na,    n_na;
    logic [SW-1:0]         r_nd,    n_nd;
    logic [SW-1:0]         r_pa,    n_pa;
    logic [SW-1:0]         r_pd,    n_pd;
    logic                  r_valid, n_valid;
    t_out                  r_res,   n_res;

    logic                  rd_en;
    logic [SW-1:0]         rd_a;
    logic [SW:0]           nx_a, nx_b;
    logic [SW-1:0]         pv_a;
    logic                  nx_we, pv_we, dt_we;
    logic [SW-1:0]         nx_wa, pv_wa, pv_wd, dt_wa;
    logic [SW:0]           nx_wd;
    logic [DATA_WIDTH-1:0] dt_wd;
    logic                  pos_in_range;
    logic                  unlink_bad;

    alle_store #(
        .SW         (SW),
        .NSLOTS     (NSLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rd_en (rd_en),
        .i_rd_a  (rd_a),
        .i_rd_b  (r_free),
        .o_nx_a  (nx_a),
        .o_nx_b  (nx_b),
        .o_pv_a  (pv_a),
        .i_nx_we (nx_we),
        .i_nx_wa (nx_wa),
        .i_nx_wd (nx_wd),
        .i_pv_we (pv_we),
        .i_pv_wa (pv_wa),
        .i_pv_wd (pv_wd),
        .i_dt_we (dt_we),
        .i_dt_wa (dt_wa),
        .i_dt_wd (dt_wd)
    );

    assign pos_in_range = ({9'd0, i_in.position} <= CAP17);
    assign unlink_bad   = !r_pos_ok || (r_tgt == '0) || !nx_a[SW];

    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_op     = r_op;
        n_val    = r_val;
        n_pos_ok = r_pos_ok;
        n_tgt    = r_tgt;
        n_free   = r_free;
        n_count  = r_count;
        n_head   = r_head;
        n_tail   = r_tail;
        n_slot   = r_slot;
        n_na     = r_na;
        n_nd     = r_nd;
        n_pa     = r_pa;
        n_pd     = r_pd;
        n_valid  = 1'b0;
        n_res    = r_res;
        rd_en    = 1'b0;
        rd_a     = '0;
        nx_we    = 1'b0;
        nx_wa    = '0;
        nx_wd    = '0;
        pv_we    = 1'b0;
        pv_wa    = '0;
        pv_wd    = '0;
        dt_we    = 1'b0;
        dt_wa    = '0;
        dt_wd    = '1;

        case (r_state)
            S_INIT: begin
                nx_we = 1'b1;
                nx_wa = r_init;
                nx_wd = {(r_init == '0),
                         ((r_init == '0) || (r_init == LAST_SLOT)) ? '0 : r_init + 1'b1};
                pv_we = 1'b1;
                pv_wa = r_init;
                dt_we = 1'b1;
                dt_wa = r_init;
                if (r_init == LAST_SLOT) begin
                    n_state = S_IDLE;
                end else begin
                    n_init = r_init + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    rd_en    = 1'b1;
                    n_op     = i_in.opcode;
                    n_val    = DATA_WIDTH'(i_in.value);
                    n_pos_ok = 1'b1;
                    case (i_in.opcode)
                        OP_PUSH_BACK, OP_POP_BACK: begin
                            rd_a = r_tail;
                        end
                        OP_INSERT, OP_ERASE: begin
                            n_pos_ok = pos_in_range;
                            rd_a     = pos_in_range ? SW'(i_in.position) : '0;
                        end
                        default: begin
                            rd_a = '0;
                        end
                    endcase
                    n_tgt   = rd_a;
                    n_state = S_E1;
                end
            end
            S_E1: begin
                n_res.status     = ST_OK;
                n_res.slot       = '0;
                n_res.count      = 8'(r_count);
                n_res.first_slot = 8'(r_head);
                n_res.last_slot  = 8'(r_tail);
                n_state          = S_IDLE;
                n_valid          = 1'b1;
                case (r_op)
                    OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                        if (r_free == '0) begin
                            n_res.status = ST_FULL;
                        end else if (!r_pos_ok || !nx_a[SW]) begin
                            n_res.status = ST_BAD;
                        end else begin
                            nx_we   = 1'b1;
                            nx_wa   = r_free;
                            nx_wd   = {1'b1, nx_a[SW-1:0]};
                            pv_we   = 1'b1;
                            pv_wa   = r_free;
                            pv_wd   = r_tgt;
                            dt_we   = 1'b1;
                            dt_wa   = r_free;
                            dt_wd   = r_val;
                            n_free  = nx_b[SW-1:0];
                            n_count = r_count + 1'b1;
                            n_slot  = r_free;
                            n_na    = r_tgt;
                            n_nd    = r_free;
                            n_pa    = nx_a[SW-1:0];
                            n_pd    = r_free;
                            n_valid = 1'b0;
                            n_state = S_E2;
                        end
                    end
                    OP_ERASE, OP_POP_BACK: begin
                        if ((r_op == OP_POP_BACK) && (r_count == '0)) begin
                            n_res.status = ST_EMPTY;
                        end else if (unlink_bad) begin
                            n_res.status = ST_BAD;
                        end else begin
                            nx_we   = 1'b1;
                            nx_wa   = r_tgt;
                            nx_wd   = {1'b0, r_free};
                            pv_we   = 1'b1;
                            pv_wa   = r_tgt;
                            pv_wd   = '0;
                            dt_we   = 1'b1;
                            dt_wa   = r_tgt;
                            n_free  = r_tgt;
                            n_count = (r_count != '0) ? r_count - 1'b1 : r_count;
                            n_slot  = r_tgt;
                            n_na    = pv_a;
                            n_nd    = nx_a[SW-1:0];
                            n_pa    = nx_a[SW-1:0];
                            n_pd    = pv_a;
                            n_valid = 1'b0;
                            n_state = S_E2;
                        end
                    end
                    default: begin
                        n_res.status = ST_BAD;
                    end
                endcase
            end
            S_E2: begin
                nx_we = 1'b1;
                nx_wa = r_na;
                nx_wd = {1'b1, r_nd};
                pv_we = 1'b1;
                pv_wa = r_pa;
                pv_wd = r_pd;
                if (r_na == '0) begin
                    n_head = r_nd;
                end
                if (r_pa == '0) begin
                    n_tail = r_pd;
                end
                n_res.status     = ST_OK;
                n_res.slot       = 8'(r_slot);
                n_res.count      = 8'(r_count);
                n_res.first_slot = 8'(n_head);
                n_res.last_slot  = 8'(n_tail);
                n_valid          = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_free  <= SW'(1);
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_free  <= n_free;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_pos_ok <= n_pos_ok;
        r_tgt    <= n_tgt;
        r_slot   <= n_slot;
        r_na     <= n_na;
        r_nd     <= n_nd;
        r_pa     <= n_pa;
        r_pd     <= n_pd;
        r_res    <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_E1))
        else $error("accepted command did not enter execute");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == S_E1 || $past(r_state) == S_E2))
        else $error("result strobe without execute cycle");

    a_free_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> ((r_free == '0) == (r_count == LAST_SLOT)))
        else $error("free chain and element count disagree");
`endif

endmodule
